// ===== hdl/tach_filter_setpoint_ramp_top_assert.svh =====
// Assertion shorthands for the block that checks itself.
// Both expect clk and rst_n in scope.
`ifndef TACH_FILTER_SETPOINT_RAMP_TOP_ASSERT_SVH
`define TACH_FILTER_SETPOINT_RAMP_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TFSR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TFSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tfsr_pkg.sv =====
`default_nettype none

package tfsr_pkg;

    // Field widths
    localparam int unsigned SPEED_W     = 16;
    localparam int unsigned MAX_SPEED_W = 8;
    localparam int unsigned STEP_W      = 16;
    localparam int unsigned ALPHA_W     = 16;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 2;

    // Parameter defaults
    localparam int unsigned AVG_DEPTH_DEF   = 50;
    localparam int unsigned SAMPLE_BITS_DEF = 10;

    // 255.0 full scale in Q8.8
    localparam logic [SPEED_W-1:0] SCALE_NUM = 16'hFF00;
    // 8.0 in Q8.8, one bit wider for the compare
    localparam logic [SPEED_W:0] OVERLOAD_MARGIN = 17'd2048;

    // Register reset values
    localparam logic [MAX_SPEED_W-1:0] MAX_SPEED_RST  = 8'd150;
    localparam logic [STEP_W-1:0]      RAMP_UP_RST    = 16'd5;
    localparam logic [STEP_W-1:0]      RAMP_DOWN_RST  = 16'd13;
    localparam logic [ALPHA_W-1:0]     ALPHA_RST      = 16'd5898;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_SPEED = 2'd0,
        CFG_RAMP_UP   = 2'd1,
        CFG_RAMP_DOWN = 2'd2,
        CFG_ALPHA     = 2'd3
    } cfg_index_t;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_MUL     = 9'b000000010,
        ST_FOLD    = 9'b000000100,
        ST_SHIFT   = 9'b000001000,
        ST_AVG_MUL = 9'b000010000,
        ST_AVG     = 9'b000100000,
        ST_EMA_MUL = 9'b001000000,
        ST_EMA     = 9'b010000000,
        ST_RAMP    = 9'b100000000
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/tfsr_in_if.sv =====
`default_nettype none

interface tfsr_in_if
    import tfsr_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] tach_sample;
    logic [SAMPLE_BITS-1:0] pot_sample;
    logic                   start_press;
    logic                   stop_press;

    modport source (
        output valid,
        output tach_sample,
        output pot_sample,
        output start_press,
        output stop_press,
        input  ready
    );

    modport sink (
        input  valid,
        input  tach_sample,
        input  pot_sample,
        input  start_press,
        input  stop_press,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/tfsr_out_if.sv =====
`default_nettype none

interface tfsr_out_if
    import tfsr_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [SPEED_W-1:0]     filtered_speed;
    logic [SPEED_W-1:0]     setpoint_value;
    logic [MAX_SPEED_W-1:0] target_speed;
    logic                   overload_alarm;
    logic                   controller_hold;
    logic                   accel_phase;
    logic                   motor_running;

    modport source (
        output valid,
        output filtered_speed,
        output setpoint_value,
        output target_speed,
        output overload_alarm,
        output controller_hold,
        output accel_phase,
        output motor_running,
        input  ready
    );

    modport sink (
        input  valid,
        input  filtered_speed,
        input  setpoint_value,
        input  target_speed,
        input  overload_alarm,
        input  controller_hold,
        input  accel_phase,
        input  motor_running,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/tfsr_cell.sv =====
`default_nettype none

// One reading of the averaging window; passes its value on when the window moves.
module tfsr_cell
    import tfsr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               shift_en,
    input  wire logic [SPEED_W-1:0] din,
    output logic      [SPEED_W-1:0] dout
);

    logic [SPEED_W-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (shift_en)
        begin
            value_reg <= din;
        end
    end

    assign dout = value_reg;

endmodule

`default_nettype wire

// ===== hdl/tfsr_chain.sv =====
`default_nettype none

// Averaging window as a row of cells; the last cell holds the reading
// that drops out on the next shift.
module tfsr_chain
    import tfsr_pkg::*;
#(
    parameter int unsigned AVG_DEPTH = AVG_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               shift_en,
    input  wire logic [SPEED_W-1:0] din,
    output logic      [SPEED_W-1:0] oldest
);

    logic [SPEED_W-1:0] link [0:AVG_DEPTH];

    assign link[0] = din;

    for (genvar k = 0; k < AVG_DEPTH; k++)
    begin : g_cell
        tfsr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .din      (link[k]),
            .dout     (link[k+1])
        );
    end

    assign oldest = link[AVG_DEPTH];

endmodule

`default_nettype wire

// ===== hdl/tach_filter_setpoint_ramp_top.sv =====
// Tach filter with knob target and setpoint ramp. Each transfer on sample carries one
// tach reading, one knob reading and the start/stop clicks; one transfer on result
// follows with the filtered speed, the ramped setpoint, the knob target and the status
// flags. The block accepts in idle, then walks a fixed sequence of eight steps (sample
// and knob products, fold divide by full scale, window shift, average product, average,
// filter product, filter update, setpoint ramp), one step per cycle, with one item in
// flight. The last step waits only if the previous result still sits in the output
// register, and no new item is accepted until the sequence is back in idle. The tach
// reading is averaged over a window of AVG_DEPTH cells that reset clears. The user must
// see that registers are written through cfg_we/cfg_index/cfg_data only while no item
// is in flight; the block itself does not enforce it. Start and stop take effect after
// the item that carries them, stop wins.
`default_nettype none
`include "tach_filter_setpoint_ramp_top_assert.svh"

module tach_filter_setpoint_ramp_top
    import tfsr_pkg::*;
#(
    parameter int unsigned AVG_DEPTH   = AVG_DEPTH_DEF,
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    tfsr_in_if.sink                     sample,
    tfsr_out_if.source                  result,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // Widths derived from the parameters
    localparam int unsigned PW        = SAMPLE_BITS + SPEED_W;
    localparam int unsigned TOTAL_W   = SPEED_W + $clog2(AVG_DEPTH);
    localparam int unsigned AVG_SHIFT = TOTAL_W + $clog2(AVG_DEPTH);
    localparam int unsigned AVG_MUL_W = TOTAL_W + 2;
    localparam int unsigned AVG_PW    = TOTAL_W + AVG_MUL_W;
    localparam int unsigned FOLD_STEPS = 3;
    localparam logic [PW-1:0] FULL_SCALE = PW'((64'd1 << SAMPLE_BITS) - 64'd1);
    // Reciprocal of the window depth, rounded up, exact for any window total
    localparam logic [63:0] AVG_MUL_FULL =
        ((64'd1 << AVG_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
    localparam logic [AVG_MUL_W-1:0] AVG_MUL = AVG_MUL_FULL[AVG_MUL_W-1:0];

    // Floor of p / (2^SAMPLE_BITS - 1): p = q*2^n + r = q*F + (q + r), folded
    // until the residue is below 2F, then one correction.
    function automatic logic [PW-1:0] fs_div(input logic [PW-1:0] p);
        logic [PW-1:0] v;
        logic [PW-1:0] q;
        v = p;
        q = '0;
        for (int k = 0; k < FOLD_STEPS; k++)
        begin
            q = q + (v >> SAMPLE_BITS);
            v = (v >> SAMPLE_BITS) + (v & FULL_SCALE);
        end
        if (v >= FULL_SCALE)
        begin
            q = q + PW'(1);
        end
        return q;
    endfunction

    // Configuration registers
    logic [MAX_SPEED_W-1:0] max_speed_reg;
    logic [STEP_W-1:0]      ramp_up_reg;
    logic [STEP_W-1:0]      ramp_down_reg;
    logic [ALPHA_W-1:0]     alpha_reg;

    // Control state
    state_t                 state_reg;
    state_t                 state_next;
    logic [TOTAL_W-1:0]     total_reg;
    logic [TOTAL_W-1:0]     total_next;
    logic [SPEED_W-1:0]     smooth_reg;
    logic [SPEED_W-1:0]     smooth_next;
    logic [SPEED_W-1:0]     ramp_reg;
    logic [SPEED_W-1:0]     ramp_next;
    logic                   enabled_reg;
    logic                   enabled_next;
    logic                   ramping_reg;
    logic                   ramping_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    // Per-item working registers
    logic [SAMPLE_BITS-1:0] tach_reg;
    logic [SAMPLE_BITS-1:0] pot_reg;
    logic                   start_reg;
    logic                   stop_reg;
    logic [PW-1:0]          prod_tach_reg;
    logic [PW-1:0]          prod_pot_reg;
    logic [SPEED_W-1:0]     scaled_reg;
    logic [MAX_SPEED_W-1:0] target_reg;
    logic [AVG_PW-1:0]      prod_avg_reg;
    logic [SPEED_W-1:0]     diff_reg;
    logic                   up_reg;
    logic [2*SPEED_W-1:0]   prod_ema_reg;

    // Output register
    logic [SPEED_W-1:0]     out_speed_reg;
    logic [SPEED_W-1:0]     out_setpoint_reg;
    logic [MAX_SPEED_W-1:0] out_target_reg;
    logic                   out_overload_reg;
    logic                   out_hold_reg;
    logic                   out_accel_reg;
    logic                   out_running_reg;

    logic                   accept;
    logic                   out_free;
    logic                   commit;
    logic [SPEED_W-1:0]     oldest;
    logic [SPEED_W-1:0]     avg;
    logic [2*SPEED_W-1:0]   ema_round;
    logic [SPEED_W:0]       ramp_sum;
    logic [SPEED_W-1:0]     target_q;
    logic [SPEED_W-1:0]     ramp_new;
    logic                   ramping_mid;
    logic                   overload;
    logic                   hold;

    assign accept   = sample.valid && sample.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign commit   = (state_reg == ST_RAMP) && out_free;
    assign sample.ready = (state_reg == ST_IDLE);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= MAX_SPEED_RST;
            ramp_up_reg   <= RAMP_UP_RST;
            ramp_down_reg <= RAMP_DOWN_RST;
            alpha_reg     <= ALPHA_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MAX_SPEED: max_speed_reg <= cfg_data[MAX_SPEED_W-1:0];
                CFG_RAMP_UP:   ramp_up_reg   <= cfg_data[STEP_W-1:0];
                CFG_RAMP_DOWN: ramp_down_reg <= cfg_data[STEP_W-1:0];
                CFG_ALPHA:     alpha_reg     <= cfg_data[ALPHA_W-1:0];
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (sample.valid) state_next = ST_MUL;
            ST_MUL:     state_next = ST_FOLD;
            ST_FOLD:    state_next = ST_SHIFT;
            ST_SHIFT:   state_next = ST_AVG_MUL;
            ST_AVG_MUL: state_next = ST_AVG;
            ST_AVG:     state_next = ST_EMA_MUL;
            ST_EMA_MUL: state_next = ST_EMA;
            ST_EMA:     state_next = ST_RAMP;
            ST_RAMP:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Averaging window
    tfsr_chain #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (state_reg == ST_SHIFT),
        .din      (scaled_reg),
        .oldest   (oldest)
    );

    // Running window total
    always_comb
    begin
        total_next = total_reg;
        if (state_reg == ST_SHIFT)
        begin
            total_next = total_reg - TOTAL_W'(oldest) + TOTAL_W'(scaled_reg);
        end
    end

    // Exponential filter: round toward minus infinity in both directions
    assign avg       = prod_avg_reg[AVG_SHIFT +: SPEED_W];
    assign ema_round = prod_ema_reg + 32'h0000FFFF;

    always_comb
    begin
        smooth_next = smooth_reg;
        if (state_reg == ST_EMA)
        begin
            if (up_reg)
            begin
                smooth_next = smooth_reg + prod_ema_reg[2*SPEED_W-1:SPEED_W];
            end
            else
            begin
                smooth_next = smooth_reg - ema_round[2*SPEED_W-1:SPEED_W];
            end
        end
    end

    // Setpoint ramp, overload and hold
    assign ramp_sum = {1'b0, ramp_reg} + {1'b0, ramp_up_reg};
    assign target_q = {target_reg, 8'h00};

    always_comb
    begin
        ramp_new    = ramp_reg;
        ramping_mid = ramping_reg;
        overload    = 1'b0;
        hold        = 1'b0;
        if (enabled_reg)
        begin
            if (ramping_reg)
            begin
                ramp_new = (ramp_sum < {1'b0, target_q}) ? ramp_sum[SPEED_W-1:0] : target_q;
                if (smooth_reg >= target_q)
                begin
                    ramping_mid = 1'b0;
                end
            end
            else
            begin
                ramp_new = target_q;
            end
            overload = !ramping_mid
                && ({1'b0, ramp_new} >= ({1'b0, smooth_reg} + OVERLOAD_MARGIN));
        end
        else
        begin
            ramp_new = (ramp_reg > ramp_down_reg) ? ramp_reg - ramp_down_reg : '0;
            hold     = (ramp_new == '0);
        end
    end

    // Motor flags: clicks act after this item, stop wins
    always_comb
    begin
        ramp_next    = ramp_reg;
        enabled_next = enabled_reg;
        ramping_next = ramping_reg;
        if (commit)
        begin
            ramp_next    = ramp_new;
            ramping_next = ramping_mid;
            if (start_reg && !enabled_reg)
            begin
                enabled_next = 1'b1;
                ramping_next = 1'b1;
            end
            if (stop_reg)
            begin
                enabled_next = 1'b0;
                ramping_next = 1'b0;
            end
        end
    end

    // Output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            smooth_reg    <= '0;
            ramp_reg      <= '0;
            enabled_reg   <= 1'b0;
            ramping_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            smooth_reg    <= smooth_next;
            ramp_reg      <= ramp_next;
            enabled_reg   <= enabled_next;
            ramping_reg   <= ramping_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers, one step per state
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tach_reg  <= sample.tach_sample;
            pot_reg   <= sample.pot_sample;
            start_reg <= sample.start_press;
            stop_reg  <= sample.stop_press;
        end
        if (state_reg == ST_MUL)
        begin
            prod_tach_reg <= {{SPEED_W{1'b0}}, tach_reg} * PW'(SCALE_NUM);
            prod_pot_reg  <= {{SPEED_W{1'b0}}, pot_reg}
                * {{(PW-MAX_SPEED_W){1'b0}}, max_speed_reg};
        end
        if (state_reg == ST_FOLD)
        begin
            scaled_reg <= SPEED_W'(fs_div(prod_tach_reg));
            target_reg <= MAX_SPEED_W'(fs_div(prod_pot_reg));
        end
        if (state_reg == ST_AVG_MUL)
        begin
            prod_avg_reg <= {{AVG_MUL_W{1'b0}}, total_reg} * {{TOTAL_W{1'b0}}, AVG_MUL};
        end
        if (state_reg == ST_AVG)
        begin
            up_reg   <= (avg >= smooth_reg);
            diff_reg <= (avg >= smooth_reg) ? avg - smooth_reg : smooth_reg - avg;
        end
        if (state_reg == ST_EMA_MUL)
        begin
            prod_ema_reg <= {{SPEED_W{1'b0}}, alpha_reg} * {{SPEED_W{1'b0}}, diff_reg};
        end
        if (commit)
        begin
            out_speed_reg    <= smooth_reg;
            out_setpoint_reg <= ramp_new;
            out_target_reg   <= target_reg;
            out_overload_reg <= overload;
            out_hold_reg     <= hold;
            out_accel_reg    <= ramping_reg;
            out_running_reg  <= enabled_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.filtered_speed  = out_speed_reg;
    assign result.setpoint_value  = out_setpoint_reg;
    assign result.target_speed    = out_target_reg;
    assign result.overload_alarm  = out_overload_reg;
    assign result.controller_hold = out_hold_reg;
    assign result.accel_phase     = out_accel_reg;
    assign result.motor_running   = out_running_reg;

    // Checks
    `TFSR_ASSERT_NEXT(a_accept_starts, accept, state_reg == ST_MUL,
        "accepted item did not start the sequence")
    `TFSR_ASSERT_NEXT(a_fold_bounds, state_reg == ST_FOLD,
        scaled_reg <= SCALE_NUM && target_reg <= max_speed_reg,
        "fold divide result out of range")
    `TFSR_ASSERT_SAME(a_flags_exclusive, result.valid,
        !(result.overload_alarm && result.controller_hold),
        "overload and hold both set")
    `TFSR_ASSERT_SAME(a_follow_target,
        result.valid && result.motor_running && !result.accel_phase,
        result.setpoint_value[15:8] == result.target_speed
            && result.setpoint_value[7:0] == 8'h00,
        "setpoint does not follow target after ramp")
    `TFSR_ASSERT_SAME(a_ramp_capped, result.valid && result.motor_running,
        result.setpoint_value[15:8] < result.target_speed
            || (result.setpoint_value[15:8] == result.target_speed
                && result.setpoint_value[7:0] == 8'h00),
        "setpoint above target while running")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tfsr_pkg::*;

    localparam int unsigned FULL_SCALE = (1 << SAMPLE_BITS_DEF) - 1;
    localparam int unsigned SETTLE_CYCLES = 12;

    typedef logic [SAMPLE_BITS_DEF-1:0] sample_t;

    typedef struct packed {
        logic [SPEED_W-1:0]     speed;
        logic [SPEED_W-1:0]     setpoint;
        logic [MAX_SPEED_W-1:0] target;
        logic                   overload;
        logic                   hold;
        logic                   accel;
        logic                   running;
    } loop_status_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    cfg_index_t             cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tfsr_in_if  sample_ch ();
    tfsr_out_if result_ch ();

    tach_filter_setpoint_ramp_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch.sink),
        .result    (result_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copies used by the predictor
    logic [MAX_SPEED_W-1:0] max_speed_r = MAX_SPEED_RST;
    logic [STEP_W-1:0]      ramp_up_r   = RAMP_UP_RST;
    logic [STEP_W-1:0]      ramp_down_r = RAMP_DOWN_RST;
    logic [ALPHA_W-1:0]     alpha_r     = ALPHA_RST;

    // Predictor state
    bit [31:0] speed_ring [AVG_DEPTH_DEF] = '{default: '0};
    bit [31:0] ring_sum   = '0;
    int        ring_pos   = 0;
    bit [31:0] smoothed   = '0;
    bit [31:0] setpoint   = '0;
    bit        enabled    = 1'b0;
    bit        ramping    = 1'b0;

    loop_status_t loop_status_q [$];

    int error_count = 0;
    int items_sent  = 0;
    bit src_gaps    = 1'b0;
    bit sink_stalls = 1'b0;
    int holdoff_len = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // Predict one result and advance the model state
    function automatic loop_status_t compute_loop_status(sample_t tach, sample_t pot,
                                                         logic start_btn, logic stop_btn);
        loop_status_t rpt;
        bit [31:0]    scaled;
        bit [31:0]    avg;
        bit [31:0]    delta;
        bit [31:0]    target;
        bit [31:0]    target_q;
        bit [31:0]    next_sp;
        bit [47:0]    prod;

        rpt = '0;
        rpt.running = enabled;
        rpt.accel   = ramping;

        // boxcar over the ring, then exponential filter
        scaled = (32'(tach) * 32'(SCALE_NUM)) / FULL_SCALE;
        ring_sum = ring_sum - speed_ring[ring_pos] + scaled;
        speed_ring[ring_pos] = scaled;
        ring_pos = (ring_pos == AVG_DEPTH_DEF - 1) ? 0 : ring_pos + 1;
        avg = ring_sum / AVG_DEPTH_DEF;
        if (avg >= smoothed)
        begin
            prod  = 48'(alpha_r) * 48'(avg - smoothed);
            delta = 32'(prod >> 16);
            smoothed = (smoothed + delta) & 32'hFFFF;
        end
        else
        begin
            prod  = 48'(alpha_r) * 48'(smoothed - avg) + 48'd65535;
            delta = 32'(prod >> 16);
            smoothed = (smoothed - delta) & 32'hFFFF;
        end

        target   = (32'(pot) * 32'(max_speed_r)) / FULL_SCALE;
        target_q = target << 8;

        // setpoint ramp
        if (enabled)
        begin
            if (ramping)
            begin
                next_sp  = setpoint + 32'(ramp_up_r);
                setpoint = (next_sp < target_q) ? next_sp : target_q;
                if (smoothed >= target_q)
                    ramping = 1'b0;
            end
            else
                setpoint = target_q;
            if (!ramping && setpoint >= smoothed + 32'(OVERLOAD_MARGIN))
                rpt.overload = 1'b1;
        end
        else
        begin
            setpoint = (setpoint > 32'(ramp_down_r)) ? setpoint - 32'(ramp_down_r) : '0;
            if (setpoint == 0)
                rpt.hold = 1'b1;
        end
        setpoint &= 32'hFFFF;

        // clicks apply after this step, stop wins
        if (start_btn && !enabled)
        begin
            enabled = 1'b1;
            ramping = 1'b1;
        end
        if (stop_btn)
        begin
            enabled = 1'b0;
            ramping = 1'b0;
        end

        rpt.speed    = smoothed[15:0];
        rpt.setpoint = setpoint[15:0];
        rpt.target   = target[7:0];
        return rpt;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // Result checker
    always @(posedge clk)
    begin
        loop_status_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (loop_status_q.size() == 0)
                report_mismatch("result transfer with nothing expected");
            else
            begin
                want = loop_status_q.pop_front();
                check_field("filtered_speed", result_ch.filtered_speed, want.speed);
                check_field("setpoint_value", result_ch.setpoint_value, want.setpoint);
                check_field("target_speed", 16'(result_ch.target_speed), 16'(want.target));
                check_field("overload_alarm", 16'(result_ch.overload_alarm),
                            16'(want.overload));
                check_field("controller_hold", 16'(result_ch.controller_hold),
                            16'(want.hold));
                check_field("accel_phase", 16'(result_ch.accel_phase), 16'(want.accel));
                check_field("motor_running", 16'(result_ch.motor_running),
                            16'(want.running));
            end
        end
    end

    // Result receiver: random stalls plus requested long hold-offs
    initial
    begin
        int n;
        forever
        begin
            if (holdoff_len != 0)
            begin
                n = holdoff_len;
                holdoff_len = 0;
                result_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (sink_stalls && $urandom_range(0, 99) < 30)
            begin
                n = pick_gap();
                result_ch.ready <= 1'b0;
                repeat ((n == 0) ? 1 : n) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // One sample transfer; valid stays up across back-to-back items
    task automatic send_sample(input sample_t tach, input sample_t pot,
                               input logic start_btn, input logic stop_btn);
        int gap;
        gap = src_gaps ? pick_gap() : 0;
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.tach_sample <= tach;
        sample_ch.pot_sample  <= pot;
        sample_ch.start_press <= start_btn;
        sample_ch.stop_press  <= stop_btn;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        loop_status_q.push_back(compute_loop_status(tach, pot, start_btn, stop_btn));
        items_sent++;
    endtask

    task automatic send_noise();
        send_sample(sample_t'($urandom), sample_t'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (loop_status_q.size() != 0);
    endtask

    // Drained and past the block's latency: safe for register writes
    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(input logic [MAX_SPEED_W-1:0] ms, input logic [STEP_W-1:0] up,
                                input logic [STEP_W-1:0] dn, input logic [ALPHA_W-1:0] al);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_SPEED;
        cfg_data  <= CFG_DATA_W'(ms);
        @(posedge clk);
        cfg_index <= CFG_RAMP_UP;
        cfg_data  <= up;
        @(posedge clk);
        cfg_index <= CFG_RAMP_DOWN;
        cfg_data  <= dn;
        @(posedge clk);
        cfg_index <= CFG_ALPHA;
        cfg_data  <= al;
        @(posedge clk);
        cfg_we <= 1'b0;
        max_speed_r = ms;
        ramp_up_r   = up;
        ramp_down_r = dn;
        alpha_r     = al;
    endtask

    // Start, run with tach shaped toward the target, stop, coast down
    task automatic run_session(input int run_len, input int stop_len);
        sample_t pot;
        int      mode;
        int      tgt_tach;
        int      t;
        pot  = sample_t'($urandom);
        mode = $urandom_range(0, 2);
        tgt_tach = ((int'(pot) * int'(max_speed_r)) / FULL_SCALE) * 4;
        send_sample(sample_t'($urandom), pot, 1'b1, 1'b0);
        for (int i = 0; i < run_len; i++)
        begin
            case (mode)
                0: t = tgt_tach + $urandom_range(0, 40) - 20;
                1: t = $urandom_range(800, FULL_SCALE);
                default: t = (tgt_tach * $urandom_range(0, 70)) / 100;
            endcase
            t = (t < 0) ? 0 : (t > FULL_SCALE) ? FULL_SCALE : t;
            if ($urandom_range(0, 99) < 4)
                send_sample(sample_t'(t), pot, 1'($urandom), 1'($urandom));
            else
                send_sample(sample_t'(t), pot, 1'b0, 1'b0);
        end
        send_sample(sample_t'($urandom), pot, 1'b0, 1'b1);
        for (int i = 0; i < stop_len; i++)
            send_sample(sample_t'($urandom_range(0, tgt_tach)), pot, 1'b0, 1'b0);
    endtask

    // Field extremes and button corner cases at reset settings
    task automatic test_field_extremes();
        send_sample('0, '0, 1'b0, 1'b0);
        send_sample(sample_t'(FULL_SCALE), sample_t'(FULL_SCALE), 1'b0, 1'b0);
        send_sample(sample_t'(FULL_SCALE), sample_t'(FULL_SCALE), 1'b1, 1'b0);
        send_sample(sample_t'(FULL_SCALE), sample_t'(FULL_SCALE), 1'b0, 1'b0);
        // start while running has no effect
        send_sample(10'h200, sample_t'(FULL_SCALE), 1'b1, 1'b0);
        // zero target ends the ramp at once
        send_sample(sample_t'(FULL_SCALE), '0, 1'b0, 1'b0);
        // setpoint follows target, speed far below: overload
        send_sample('0, sample_t'(FULL_SCALE), 1'b0, 1'b0);
        send_sample('0, sample_t'(FULL_SCALE), 1'b0, 1'b0);
        // start and stop together while running
        send_sample('0, sample_t'(FULL_SCALE), 1'b1, 1'b1);
        // stopped well below setpoint: no overload, ramp down
        send_sample('0, sample_t'(FULL_SCALE), 1'b0, 1'b0);
        // start and stop together while stopped
        send_sample(10'h2AA, 10'h155, 1'b1, 1'b1);
        send_sample(10'h155, 10'h2AA, 1'b0, 1'b1);
        send_sample(10'h2AA, 10'h155, 1'b0, 1'b0);
    endtask

    // Register extremes, including full-scale max_speed
    task automatic test_extreme_settings();
        apply_config(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(sample_t'(FULL_SCALE), sample_t'(FULL_SCALE), 1'b1, 1'b0);
        send_sample(sample_t'(FULL_SCALE), sample_t'(FULL_SCALE), 1'b0, 1'b0);
        // filter pulled down with round-up of the step
        send_sample('0, sample_t'(FULL_SCALE), 1'b0, 1'b1);
        // ramp down saturates at zero
        send_sample('0, sample_t'(FULL_SCALE), 1'b0, 1'b0);
        apply_config('0, '0, '0, '0);
        send_sample(sample_t'(FULL_SCALE), sample_t'(FULL_SCALE), 1'b1, 1'b0);
        send_sample(sample_t'(FULL_SCALE), sample_t'(FULL_SCALE), 1'b0, 1'b0);
        send_sample('0, '0, 1'b0, 1'b1);
        send_sample('0, '0, 1'b0, 1'b0);
    endtask

    // Receiver holds off while items keep coming, so the input stalls
    task automatic test_stall_pressure();
        apply_config(8'd200, 16'd900, 16'd700, 16'd20000);
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        holdoff_len = 300;
        for (int i = 0; i < 16; i++)
            send_noise();
    endtask

    // Sender pauses until every result is back, then resumes
    task automatic test_drain_pause();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        run_session(15, 5);
        wait_drained();
        run_session(15, 5);
    endtask

    task automatic test_random_sessions();
        int goal;
        int sessions;
        goal = items_sent + 1900;
        sessions = 0;
        while (items_sent < goal)
        begin
            // new settings every few sessions, extremes now and then
            if (sessions % 4 == 0)
            begin
                case (sessions / 4 % 4)
                    0: apply_config(MAX_SPEED_RST, RAMP_UP_RST, RAMP_DOWN_RST, ALPHA_RST);
                    1: apply_config(8'd254, 16'd1, 16'd65535, 16'd65535);
                    default:
                        apply_config(($urandom_range(0, 9) == 0) ? 8'd255
                                                                  : 8'($urandom_range(20, 254)),
                                     16'($urandom_range(16, 3000)),
                                     16'($urandom_range(16, 3000)),
                                     ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 500))
                                                                 : 16'($urandom_range(3000, 40000)));
                endcase
            end
            src_gaps    = ($urandom_range(0, 9) < 7);
            sink_stalls = ($urandom_range(0, 9) < 7);
            run_session($urandom_range(20, 140), $urandom_range(5, 60));
            repeat ($urandom_range(0, 5))
                send_noise();
            sessions++;
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= CFG_MAX_SPEED;
        cfg_data              <= '0;
        sample_ch.valid       <= 1'b0;
        sample_ch.tach_sample <= '0;
        sample_ch.pot_sample  <= '0;
        sample_ch.start_press <= 1'b0;
        sample_ch.stop_press  <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_extreme_settings();
        test_stall_pressure();
        test_drain_pause();
        test_random_sessions();

        wait_idle();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
